[design/motor_command_packet_framer_macros.svh]
// ----------------------------------------------------------------------------
// Motor command packet framer assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef MOTOR_COMMAND_PACKET_FRAMER_MACROS_SVH
`define MOTOR_COMMAND_PACKET_FRAMER_MACROS_SVH

// Same-cycle implication.
`define MCPF_ASSERT_IMPLIES(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication.
`define MCPF_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

[design/mcpf_pkg.sv]
// ----------------------------------------------------------------------------
// Motor command packet framer package
// Payload types, register indexes and constants shared by the framer files.
// ----------------------------------------------------------------------------
`default_nettype none

package mcpf_pkg;

   localparam int MaxChannels    = 4;
   localparam int BytesPerPacket = 4;
   localparam int NumChannelsDef = 4;

   // Scale factor of the magnitude byte and mask of the checksum.
   localparam logic [7:0] MagScale     = 8'd127;
   localparam logic [7:0] ChecksumMask = 8'h7F;

   localparam logic [7:0] AddrReset [MaxChannels]     = '{8'd128, 8'd128, 8'd129, 8'd129};
   localparam logic [5:0] MotorSelReset [MaxChannels] = '{6'd0, 6'd1, 6'd0, 6'd1};

   typedef enum logic [2:0] {
      CSR_ADDR_0      = 3'd0,
      CSR_ADDR_1      = 3'd1,
      CSR_ADDR_2      = 3'd2,
      CSR_ADDR_3      = 3'd3,
      CSR_MOTOR_SEL_0 = 3'd4,
      CSR_MOTOR_SEL_1 = 3'd5,
      CSR_MOTOR_SEL_2 = 3'd6,
      CSR_MOTOR_SEL_3 = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] speed_0;
      logic signed [15:0] speed_1;
      logic signed [15:0] speed_2;
      logic signed [15:0] speed_3;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

[design/motor_command_packet_framer.sv]
// ----------------------------------------------------------------------------
// Motor command packet framer
// Turns four signed speed commands into a stream of serial packet bytes.
// ----------------------------------------------------------------------------
// Each accepted item carries NUM_CHANNELS signed Q1.15 speeds. The block emits
// one four-byte packet per channel, channel 0 first: the channel's address
// byte, the command byte (four times the motor number, plus one when the
// speed is negative), the magnitude floor(|speed| * 127 / 32768) and a
// checksum, the sum of the first three bytes masked to 7 bits. The final byte
// of an item has last set. An item therefore produces 4 * NUM_CHANNELS result
// items, one per cycle while rsp_ready is high, and a new item is taken in the
// same cycle that the final byte leaves the cell chain, so the sustained rate
// is set by the single output byte per cycle. Internally each channel has a
// cell that builds its packet when the item is taken and then shifts bytes
// toward channel 0 by one place per output byte. Configuration registers are
// written through csr_we, csr_index and csr_wdata and should only change while
// no item is in flight.
`default_nettype none

module motor_command_packet_framer #(
   parameter int NUM_CHANNELS = mcpf_pkg::NumChannelsDef
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire mcpf_pkg::req_type       req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output mcpf_pkg::rsp_type            rsp_data,
   input  wire                          csr_we,
   input  wire mcpf_pkg::csr_index_type csr_index,
   input  wire [7:0]                    csr_wdata
);
   import mcpf_pkg::*;

`include "motor_command_packet_framer_macros.svh"

   localparam int TotalBytes = BytesPerPacket * NUM_CHANNELS;
   localparam int CountWidth = $clog2(TotalBytes + 1);

   // Configuration registers.
   logic [7:0] addr_ff      [MaxChannels];
   logic [5:0] motor_sel_ff [MaxChannels];

   // Bytes still held in the cell chain, and the output register.
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_data_ff;
   rsp_type               rsp_data_in;

   logic                  chain_move;
   logic                  req_fire;
   logic                  final_byte;
   cell_ctrl_type         cell_ctrl;
   logic signed [15:0]    speed_vec [MaxChannels];
   logic [7:0]            head_byte [NUM_CHANNELS + 1];

   // Register writes. The index covers exactly the eight registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < MaxChannels; c++) begin
            addr_ff[c]      <= AddrReset[c];
            motor_sel_ff[c] <= MotorSelReset[c];
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_ADDR_0:      addr_ff[0]      <= csr_wdata;
            CSR_ADDR_1:      addr_ff[1]      <= csr_wdata;
            CSR_ADDR_2:      addr_ff[2]      <= csr_wdata;
            CSR_ADDR_3:      addr_ff[3]      <= csr_wdata;
            CSR_MOTOR_SEL_0: motor_sel_ff[0] <= csr_wdata[5:0];
            CSR_MOTOR_SEL_1: motor_sel_ff[1] <= csr_wdata[5:0];
            CSR_MOTOR_SEL_2: motor_sel_ff[2] <= csr_wdata[5:0];
            CSR_MOTOR_SEL_3: motor_sel_ff[3] <= csr_wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   // A byte leaves the chain whenever the chain holds one and the output
   // register is empty or being drained. The next item may enter in the same
   // cycle that the final byte leaves.
   always_comb begin
      chain_move = (count_ff != '0) && (!rsp_valid_ff || rsp_ready);
      final_byte = (count_ff == CountWidth'(1));
      req_ready  = (count_ff == '0) || (final_byte && chain_move);
      req_fire   = req_valid && req_ready;

      cell_ctrl.load  = req_fire;
      cell_ctrl.shift = chain_move && !req_fire;

      count_in = count_ff;
      if (req_fire) begin
         count_in = CountWidth'(TotalBytes);
      end else if (chain_move) begin
         count_in = count_ff - CountWidth'(1);
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (chain_move) begin
         rsp_valid_in        = 1'b1;
         rsp_data_in.tx_byte = head_byte[0];
         rsp_data_in.last    = final_byte;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Speeds in channel order.
   always_comb begin
      speed_vec[0] = req_data.speed_0;
      speed_vec[1] = req_data.speed_1;
      speed_vec[2] = req_data.speed_2;
      speed_vec[3] = req_data.speed_3;
   end

   // The cell behind the last one feeds zeros into the chain.
   assign head_byte[NUM_CHANNELS] = 8'd0;

   for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_cell
      mcpf_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .speed     (speed_vec[ch]),
         .addr      (addr_ff[ch]),
         .motor_sel (motor_sel_ff[ch]),
         .shift_in  (head_byte[ch + 1]),
         .head_byte (head_byte[ch])
      );
   end

   // An item is only taken when the chain is empty or about to be.
   `MCPF_ASSERT_IMPLIES(a_accept_when_drained, clock, reset, req_fire,
      count_ff <= CountWidth'(1), "item accepted while chain still busy")

   // A taken item fills the chain with a full item of bytes.
   `MCPF_ASSERT_NEXT(a_load_full, clock, reset, req_fire,
      count_ff == CountWidth'(TotalBytes), "chain not loaded with a full item")

   // The byte that empties the chain is the flagged one.
   `MCPF_ASSERT_NEXT(a_last_flag, clock, reset, chain_move && final_byte,
      rsp_valid_ff && rsp_data_ff.last, "final byte of item not flagged")

   // The byte count never exceeds one item.
   `MCPF_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1,
      count_ff <= CountWidth'(TotalBytes), "byte count out of range")

endmodule

`default_nettype wire

[design/mcpf_cell.sv]
// ----------------------------------------------------------------------------
// Motor command packet framer cell
// Builds one channel's four-byte packet and shifts it toward the chain head.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpf_cell (
   input  wire                          clock,
   input  wire mcpf_pkg::cell_ctrl_type ctrl,
   input  wire signed [15:0]            speed,
   input  wire [7:0]                    addr,
   input  wire [5:0]                    motor_sel,
   input  wire [7:0]                    shift_in,
   output logic [7:0]                   head_byte
);
   import mcpf_pkg::*;

   logic [7:0]  byte_ff [BytesPerPacket];
   logic [7:0]  byte_in [BytesPerPacket];
   logic        neg;
   logic [16:0] speed_ext;
   logic [16:0] abs_speed;
   logic [23:0] scaled;
   logic [7:0]  cmd_byte;
   logic [7:0]  mag_byte;
   logic [7:0]  sum_byte;

   // Magnitude is floor(|speed| * 127 / 32768); the multiply by 127 is a
   // shift and a subtract.
   always_comb begin
      neg       = speed[15];
      speed_ext = {speed[15], speed};
      abs_speed = neg ? (17'd0 - speed_ext) : speed_ext;
      scaled    = {abs_speed, 7'd0} - {7'd0, abs_speed};
      mag_byte  = scaled[22:15] & {1'b0, MagScale[6:0]};
      cmd_byte  = {motor_sel, 1'b0, neg};
      sum_byte  = (addr + cmd_byte + mag_byte) & ChecksumMask;
   end

   always_comb begin
      for (int k = 0; k < BytesPerPacket; k++) begin
         byte_in[k] = byte_ff[k];
      end
      if (ctrl.load) begin
         byte_in[0] = addr;
         byte_in[1] = cmd_byte;
         byte_in[2] = mag_byte;
         byte_in[3] = sum_byte;
      end else if (ctrl.shift) begin
         for (int k = 0; k < BytesPerPacket - 1; k++) begin
            byte_in[k] = byte_ff[k + 1];
         end
         byte_in[BytesPerPacket - 1] = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < BytesPerPacket; k++) begin
         byte_ff[k] <= byte_in[k];
      end
   end

   assign head_byte = byte_ff[0];

endmodule

`default_nettype wire

[tb/motor_command_packet_framer_tb.sv]
// ----------------------------------------------------------------------------
// Motor command packet framer testbench
// Sends speed items with random gaps and back-pressure, predicts the sixteen
// packet bytes of each item and compares every byte as it leaves the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module motor_command_packet_framer_tb;
   import mcpf_pkg::*;

   localparam int NumChan      = NumChannelsDef;
   localparam int BytesPerItem = BytesPerPacket * NumChan;
   localparam int IdlePercent  = 28;
   localparam int SettleCycles = 40;
   localparam int CycleLimit   = 400000;
   localparam int MaxReported  = 10;

   logic           clock;
   logic           reset;
   logic           req_valid;
   logic           req_ready;
   req_type        req_data;
   logic           rsp_valid;
   logic           rsp_ready;
   rsp_type        rsp_data;
   logic           csr_we;
   csr_index_type  csr_index;
   logic [7:0]     csr_wdata;

   // Our own copy of the register file, updated on every write we issue.
   logic [7:0] addr_copy [MaxChannels];
   logic [5:0] motor_sel_copy [MaxChannels];

   // Packet bytes that the block still owes us, oldest first.
   rsp_type    pending_bytes [$];

   int         mismatches;
   bit         failed;
   int         cycle_count;
   // When set, neither side inserts gaps or stalls.
   bit         steady;

   motor_command_packet_framer #(
      .NUM_CHANNELS(NumChan)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Magnitude byte: floor(|speed| * 127 / 32768). The absolute value needs
   // seventeen bits because -32768 has no positive counterpart in sixteen.
   function automatic logic [7:0] speed_to_magnitude(logic [15:0] speed);
      logic [16:0] abs_speed;
      logic [23:0] scaled;
      abs_speed = speed[15] ? (17'h10000 - {1'b0, speed}) : {1'b0, speed};
      scaled    = abs_speed * {16'd0, MagScale};
      return scaled[22:15];
   endfunction

   // Works out the bytes of all packets for one item and queues them.
   task automatic frame_speeds(req_type item);
      logic [15:0] speeds [MaxChannels];
      logic [7:0]  pkt [BytesPerPacket];
      rsp_type     expected_byte;
      int          n;
      speeds = '{item.speed_0, item.speed_1, item.speed_2, item.speed_3};
      n = 0;
      for (int ch = 0; ch < NumChan; ch++) begin
         pkt[0] = addr_copy[ch];
         // Reverse is flagged in bit 0 of the command byte.
         pkt[1] = {motor_sel_copy[ch], 1'b0, speeds[ch][15]};
         pkt[2] = speed_to_magnitude(speeds[ch]);
         pkt[3] = (pkt[0] + pkt[1] + pkt[2]) & ChecksumMask;
         for (int b = 0; b < BytesPerPacket; b++) begin
            expected_byte.tx_byte = pkt[b];
            expected_byte.last    = (n == BytesPerItem - 1);
            pending_bytes.push_back(expected_byte);
            n++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------

   // Every byte that is handed over is compared with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_bytes.size() == 0) begin
            mismatches++;
            failed = 1'b1;
            if (mismatches <= MaxReported)
               $display("[%0t] unexpected byte: tx_byte=%0d last=%0b",
                        $realtime, rsp_data.tx_byte, rsp_data.last);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_data.tx_byte !== want.tx_byte || rsp_data.last !== want.last) begin
               mismatches++;
               failed = 1'b1;
               if (mismatches <= MaxReported)
                  $display("[%0t] byte mismatch: expected tx_byte=%0d last=%0b, got tx_byte=%0d last=%0b",
                           $realtime, want.tx_byte, want.last,
                           rsp_data.tx_byte, rsp_data.last);
            end
         end
      end
   end

   // The receiver stalls about 28 percent of the time, except in a steady
   // stretch.
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IdlePercent);
   end

   // Watchdog. The limit is many times the slowest expected run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Shared stimulus tasks
   // ------------------------------------------------------------------------

   // Sends one item. Valid may be held over from the previous item, so it is
   // only lowered when a gap is chosen, and it is never lowered and raised in
   // the same step.
   task automatic send_speeds(req_type item);
      @(negedge clock);
      while (!steady && $urandom_range(99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do
         @(posedge clock);
      while (!req_ready);
      frame_speeds(item);
   endtask

   task automatic write_register(csr_index_type idx, logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      // Only the low bits that the register holds are kept.
      case (idx)
         CSR_ADDR_0:      addr_copy[0] = value;
         CSR_ADDR_1:      addr_copy[1] = value;
         CSR_ADDR_2:      addr_copy[2] = value;
         CSR_ADDR_3:      addr_copy[3] = value;
         CSR_MOTOR_SEL_0: motor_sel_copy[0] = value[5:0];
         CSR_MOTOR_SEL_1: motor_sel_copy[1] = value[5:0];
         CSR_MOTOR_SEL_2: motor_sel_copy[2] = value[5:0];
         CSR_MOTOR_SEL_3: motor_sel_copy[3] = value[5:0];
         default: ;
      endcase
   endtask

   // Lowers valid and waits until every predicted byte has been seen, then
   // a little longer so that the block is surely idle before a register write.
   task automatic wait_for_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic send_four(logic [15:0] s0, logic [15:0] s1,
                            logic [15:0] s2, logic [15:0] s3);
      req_type item;
      item.speed_0 = s0;
      item.speed_1 = s1;
      item.speed_2 = s2;
      item.speed_3 = s3;
      send_speeds(item);
   endtask

   // Mostly uniform 16-bit speeds, with the edges of the range mixed in.
   function automatic logic [15:0] random_speed();
      logic [15:0] edges [8];
      edges = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF,
                16'h0001, 16'h0102, 16'h0103, 16'hFEFD};
      if ($urandom_range(7) == 0)
         return edges[$urandom_range(7)];
      return 16'($urandom);
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset register values with the speed extremes: zero, full forward, full
   // reverse (magnitude exactly 127), one step either side of zero, and the
   // edge where the magnitude first becomes one.
   task automatic test_speed_extremes();
      send_four(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_four(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF);
      send_four(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001);
      send_four(16'h0102, 16'hFEFE, 16'h0103, 16'hFEFD);
      send_four(16'h4000, 16'hC000, 16'h7FFE, 16'h8001);
      send_four(16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00);
      wait_for_idle();
   endtask

   // Largest and smallest register settings. With motor number 63 and a
   // reverse speed the command byte reaches 253, and address 255 makes the
   // checksum sum wrap past eight bits.
   task automatic test_register_extremes();
      for (int i = 0; i < MaxChannels; i++) begin
         write_register(csr_index_type'(i), 8'd255);
         write_register(csr_index_type'(i + MaxChannels), 8'd63);
      end
      send_four(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000);
      send_four(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF);
      wait_for_idle();
      for (int i = 0; i < MaxChannels; i++) begin
         write_register(csr_index_type'(i), 8'd0);
         write_register(csr_index_type'(i + MaxChannels), 8'd0);
      end
      send_four(16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF);
      send_four(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF);
      wait_for_idle();
   endtask

   // Motor numbers written with either of the top two data bits set must drop them.
   task automatic test_wide_motor_values();
      write_register(CSR_MOTOR_SEL_0, 8'hFF);
      write_register(CSR_MOTOR_SEL_1, 8'hC2);
      write_register(CSR_MOTOR_SEL_2, 8'h81);
      write_register(CSR_MOTOR_SEL_3, 8'h55);
      write_register(CSR_ADDR_0, 8'h80);
      write_register(CSR_ADDR_1, 8'h7F);
      write_register(CSR_ADDR_2, 8'h01);
      write_register(CSR_ADDR_3, 8'hFE);
      send_four(16'h8000, 16'h0001, 16'hFFFF, 16'h7FFF);
      send_four(16'h1234, 16'hEDCB, 16'h0000, 16'h8000);
      wait_for_idle();
   endtask

   // Random items over several register settings. One phase runs with no
   // gaps or stalls at all so the block is driven at its full rate.
   task automatic test_random_traffic();
      logic [7:0] value;
      for (int phase = 0; phase < 8; phase++) begin
         for (int i = 0; i < 2 * MaxChannels; i++) begin
            case ($urandom_range(3))
               0:       value = 8'h00;
               1:       value = 8'hFF;
               default: value = 8'($urandom);
            endcase
            write_register(csr_index_type'(i), value);
         end
         steady = (phase == 3);
         for (int n = 0; n < 50; n++)
            send_four(random_speed(), random_speed(), random_speed(), random_speed());
         wait_for_idle();
         steady = 1'b0;
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_ready   = 1'b0;
      csr_we      = 1'b0;
      csr_index   = CSR_ADDR_0;
      csr_wdata   = '0;
      mismatches  = 0;
      failed      = 1'b0;
      cycle_count = 0;
      steady      = 1'b0;
      for (int ch = 0; ch < MaxChannels; ch++) begin
         addr_copy[ch]      = AddrReset[ch];
         motor_sel_copy[ch] = MotorSelReset[ch];
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_speed_extremes();
      test_register_extremes();
      test_wide_motor_values();
      test_random_traffic();

      if (pending_bytes.size() != 0) begin
         failed = 1'b1;
         $display("%0d predicted bytes never arrived", pending_bytes.size());
      end

      if (!failed) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
+incdir+design
design/mcpf_pkg.sv
design/mcpf_cell.sv
design/motor_command_packet_framer.sv
tb/motor_command_packet_framer_tb.sv
